@@ sv/binmmc_pkg.sv @@
// ----------------------------------------------------------------------------
// binmmc_pkg
// Shared types, constants and helpers of the binary MultiMMC predictor core.
// ----------------------------------------------------------------------------
package binmmc_pkg;

    localparam int ORDERS_DEF        = 16;
    localparam int COUNT_BITS_DEF    = 32;
    localparam int LIMIT_BITS        = 17;
    localparam int EPOCH_BITS        = 4;
    localparam logic [LIMIT_BITS-1:0] ENTRY_LIMIT_RESET = 17'd100000;

    // register byte offsets
    localparam logic [2:0] REG_ENTRY_LIMIT = 3'd0;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CLEAR = 5'b00010,
        S_SETUP = 5'b00100,
        S_RUN   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic start_req;
        logic bit_req;
    } t_in_beat;

    typedef struct packed {
        logic        scored;
        logic [31:0] correct_count;
        logic [31:0] longest_run;
        logic [3:0]  winner_order;
    } t_out_beat;

    function automatic logic [31:0] inc32(input logic [31:0] v);
        inc32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

@@ sv/binary_multi_mmc_predictor_core.sv @@
// ----------------------------------------------------------------------------
// binary_multi_mmc_predictor_core
// MultiMMC next-bit predictor over orders 1..ORDERS, one result beat per bit.
// ----------------------------------------------------------------------------
// Each input beat carries one sample bit and produces one result beat with the
// running hit count, longest run and winner order. After a setup step, a bit
// walks min(ORDERS, position-1) orders once position >= 2, then a done step
// issues its result beat. A new beat is taken only in the idle state, so the
// core does not take the next beat until the previous bit is through. The order
// walk makes one paired read and at most one write-back per order, with the
// read of the next order overlapped on the write of the current one. Counts
// live in a single memory with an epoch tag per word; a start beat just advances
// the epoch. After reset, and on every (2^EPOCH_BITS-1)-th start, a clearing
// pass sweeps all 2^(ORDERS+2)-4 words of the memory and no input beat is taken
// meanwhile.
// A result beat waiting at the output does not stop the next bit from starting.
// ----------------------------------------------------------------------------
module binary_multi_mmc_predictor_core #(
    parameter int ORDERS     = binmmc_pkg::ORDERS_DEF,
    parameter int COUNT_BITS = binmmc_pkg::COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  binmmc_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output binmmc_pkg::t_out_beat o_out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import binmmc_pkg::*;

    localparam int DW    = (ORDERS > 1) ? $clog2(ORDERS) : 1;
    localparam int AW    = ORDERS + 2;
    localparam int DEPTH = (1 << AW) - 4;
    localparam int HW    = ORDERS;
    localparam int WW    = EPOCH_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
    localparam logic [DW-1:0] D_LAST = DW'(ORDERS - 1);

    // count memory: {epoch tag, count}
    logic [WW-1:0] mem [DEPTH];
    logic [WW-1:0] r_rd0, r_rd1;

    t_state                  r_state;
    logic [AW-1:0]           r_clr;
    logic                    r_pend;      // clear pass started by a start beat
    logic [EPOCH_BITS-1:0]   r_epoch;
    logic [LIMIT_BITS-1:0]   r_limit;
    logic                    r_bit;
    logic [HW-1:0]           r_hist;
    logic [31:0]             r_pos;
    logic [31:0]             r_score [ORDERS];
    logic [LIMIT_BITS-1:0]   r_used  [ORDERS];
    logic [DW-1:0]           r_win, r_lead, r_d;
    logic [31:0]             r_win_score, r_run, r_best, r_hits;
    logic                    r_seen;
    logic                    r_out_valid;
    t_out_beat               r_out;

    function automatic logic [AW-1:0] f_addr(input logic [DW-1:0] d,
                                             input logic [HW-1:0] h);
        logic [HW:0]   m;
        logic [AW-1:0] base;
        m    = ((HW+1)'(1) << (d + 1)) - (HW+1)'(1);
        base = (AW'(1) << (d + 2)) - AW'(4);
        f_addr = base + AW'({h & m[HW-1:0], 1'b0});
    endfunction

    // ---- memory port control ----
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [WW-1:0]         wdata;
    logic [DW-1:0]         rd_d;
    logic [AW-1:0]         raddr;

    // ---- order step datapath ----
    logic [COUNT_BITS-1:0] c0, c1, cb, cg;
    logic                  guess, n_seen, eval, hit, room, more;
    logic [31:0]           s_new;
    logic [DW-1:0]         seed_d;
    logic                  seed_on;
    logic                  in_acc, out_free;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    assign c0 = (r_rd0[WW-1:COUNT_BITS] == r_epoch) ? r_rd0[COUNT_BITS-1:0] : '0;
    assign c1 = (r_rd1[WW-1:COUNT_BITS] == r_epoch) ? r_rd1[COUNT_BITS-1:0] : '0;
    assign eval   = (r_d == '0) || r_seen;
    assign guess  = !(c0 > c1);           // ties predict 1
    assign cg     = guess ? c1 : c0;
    assign n_seen = eval && (cg != '0);
    assign hit    = n_seen && (guess == r_bit);
    assign cb     = r_bit ? c1 : c0;
    assign room   = r_used[r_d] < r_limit;
    assign s_new  = inc32(r_score[r_d]);
    assign more   = (r_d != D_LAST) && (r_pos > 32'(r_d) + 32'd2);

    assign seed_on = (r_pos >= 32'd1) && (r_pos <= 32'(ORDERS));
    assign seed_d  = DW'(r_pos - 32'd1);

    always_comb begin
        we    = 1'b0;
        waddr = f_addr(r_d, r_hist) | AW'(r_bit);
        wdata = {r_epoch, cb + COUNT_BITS'(1)};
        rd_d  = r_d + DW'(1);
        case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
            end
            S_SETUP: begin
                rd_d  = '0;
                we    = seed_on;
                waddr = f_addr(seed_d, r_hist) | AW'(r_bit);
                wdata = {r_epoch, COUNT_BITS'(1)};
            end
            S_RUN: begin
                if (n_seen && cb != '0) begin
                    we = (cb != CMAX);
                end else if (room) begin
                    we    = 1'b1;
                    wdata = {r_epoch, COUNT_BITS'(1)};
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    assign raddr = f_addr(rd_d, r_hist);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd0 <= mem[raddr];
        r_rd1 <= mem[raddr | AW'(1)];
    end

    // ---- sequencer and predictor state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pend      <= 1'b0;
            r_epoch     <= '0;
            r_hist      <= '0;
            r_pos       <= '0;
            r_win       <= '0;
            r_lead      <= '0;
            r_d         <= '0;
            r_seen      <= 1'b0;
            r_win_score <= '0;
            r_run       <= '0;
            r_best      <= '0;
            r_hits      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < ORDERS; i++) begin
                r_score[i] <= '0;
                r_used[i]  <= '0;
            end
        end else begin
            // a beat leaving in the cycle a new one issues is replaced below
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_bit <= i_in_data.bit_req;
                        if (i_in_data.start_req) begin
                            r_hist      <= '0;
                            r_pos       <= '0;
                            r_win       <= '0;
                            r_win_score <= '0;
                            r_run       <= '0;
                            r_best      <= '0;
                            r_hits      <= '0;
                            for (int i = 0; i < ORDERS; i++) begin
                                r_score[i] <= '0;
                                r_used[i]  <= '0;
                            end
                            if (r_epoch == '1) begin
                                r_clr   <= '0;
                                r_pend  <= 1'b1;
                                r_state <= S_CLEAR;
                            end else begin
                                r_epoch <= r_epoch + EPOCH_BITS'(1);
                                r_state <= S_SETUP;
                            end
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_epoch <= EPOCH_BITS'(1);
                        r_pend  <= 1'b0;
                        r_state <= r_pend ? S_SETUP : S_IDLE;
                    end
                end
                S_SETUP: begin
                    if (seed_on) begin
                        r_used[seed_d] <= LIMIT_BITS'(1);
                    end
                    r_lead  <= r_win;
                    r_d     <= '0;
                    r_seen  <= 1'b0;
                    r_state <= (r_pos >= 32'd2) ? S_RUN : S_DONE;
                end
                S_RUN: begin
                    r_seen <= n_seen;
                    if (hit) begin
                        r_score[r_d] <= s_new;
                        if (s_new >= r_win_score) begin
                            r_win       <= r_d;
                            r_win_score <= s_new;
                        end
                        if (r_d == r_lead) begin
                            r_hits <= inc32(r_hits);
                            r_run  <= inc32(r_run);
                            if (inc32(r_run) > r_best) begin
                                r_best <= inc32(r_run);
                            end
                        end
                    end else if (n_seen && r_d == r_lead) begin
                        r_run <= '0;
                    end
                    // a new entry is created unless the bit's count was seen non-empty, while room
                    if (!(n_seen && cb != '0) && room) begin
                        r_used[r_d] <= r_used[r_d] + LIMIT_BITS'(1);
                    end
                    r_d     <= r_d + DW'(1);
                    r_state <= more ? S_RUN : S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out.scored        <= (r_pos >= 32'd2);
                        r_out.correct_count <= r_hits;
                        r_out.longest_run   <= r_best;
                        r_out.winner_order  <= 4'(r_win);
                        r_out_valid         <= 1'b1;
                        r_hist              <= HW'({r_hist, r_bit});
                        r_pos               <= inc32(r_pos);
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ---- configuration port ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= ENTRY_LIMIT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ENTRY_LIMIT[2]) begin
            r_limit <= pwdata[LIMIT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ENTRY_LIMIT[2]) ? 32'(r_limit) : 32'd0;
    assign pready = 1'b1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ sv/binmmc_checker.sv @@
// ----------------------------------------------------------------------------
// binmmc_props
// Port-level checks of the predictor core, bound to the top level.
// ----------------------------------------------------------------------------
module binmmc_props (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input binmmc_pkg::t_out_beat o_out_data,
    input logic                  pready
);
    import binmmc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_run_le_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.longest_run <= o_out_data.correct_count)
        else $error("longest run exceeds hit count");

    a_unscored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.scored |->
            o_out_data.correct_count == 32'd0 && o_out_data.winner_order == 4'd0)
        else $error("unscored beat carries totals");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind binary_multi_mmc_predictor_core binmmc_props u_binmmc_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);
